/* hw/rtl/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the run-length scanline decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    // field widths
    localparam int unsigned IN_W     = 8;
    localparam int unsigned COL_W    = 12;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned PLANE_W  = 2;
    localparam int unsigned CNT_W    = 6;
    localparam int unsigned WIDTH_W  = 13;
    localparam int unsigned HEIGHT_W = 13;
    localparam int unsigned BPL_W    = 14;
    localparam int unsigned POS_W    = 15;
    localparam int unsigned PCOL_W   = 14;
    localparam int unsigned CUR_ROW_W = 13;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 14;

    // limits of the image geometry
    localparam logic [WIDTH_W-1:0] MAX_DIM        = 13'd4096;
    localparam logic [BPL_W-1:0]   MAX_LINE_BYTES = 14'd8192;

    // marker byte pattern: both top bits set
    localparam logic [IN_W-1:0] RUN_MARK = 8'hC0;

    // plane codes
    localparam logic [PLANE_W-1:0] PLANE_RED  = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_BLUE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_LINE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RGB_MODE       = 2'd3;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    // one pixel write
    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [PLANE_W-1:0] plane;
        logic [IN_W-1:0]    value;
    } t_pixel;

endpackage

/* hw/rtl/pcx_rle_scanline_decoder.sv */
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder
// Expands a run-length coded pixel byte stream into pixel writes with
// column, row and plane, tracking line and plane position.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_byte
//  out     | output    | o_out_valid / i_out_ready | column, row, plane, value, last
//  cfg     | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
//  A marker byte, a zero-count value byte or a byte after the last row is
//  taken without leaving idle. A byte that expands to n line positions (n = 1
//  for a literal, up to 63 for a run) goes through intake, n stepper steps and the
//  release of the final write; no release when nothing is written. The stepper
//  pauses while holding stage and output register are full and i_out_ready is low.
//  Reset (synchronous, active low) clears the counters, geometry becomes 1, 1, 1.
//
module pcx_rle_scanline_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pcxrle_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pcxrle_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // input bytes
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pcxrle_pkg::IN_W-1:0]         i_in_byte,
    // pixel writes
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pcxrle_pkg::COL_W-1:0]        o_pixel_column,
    output logic [pcxrle_pkg::ROW_W-1:0]        o_pixel_row,
    output logic [pcxrle_pkg::PLANE_W-1:0]      o_plane_select,
    output logic [pcxrle_pkg::IN_W-1:0]         o_pixel_value,
    output logic                                o_last_of_run
);

    // configuration registers
    logic [pcxrle_pkg::WIDTH_W-1:0]  r_width;
    logic [pcxrle_pkg::HEIGHT_W-1:0] r_height;
    logic [pcxrle_pkg::BPL_W-1:0]    r_bpl;
    logic                            r_rgb;

    // sequencer and position state
    pcxrle_pkg::t_state r_state, n_state;
    logic                               r_awaiting, n_awaiting;
    logic [pcxrle_pkg::CNT_W-1:0]       r_pending, n_pending;
    logic [pcxrle_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [pcxrle_pkg::IN_W-1:0]        r_val, n_val;
    logic [pcxrle_pkg::POS_W-1:0]       r_pos, n_pos;
    logic [pcxrle_pkg::PLANE_W-1:0]     r_plane, n_plane;
    logic [pcxrle_pkg::PCOL_W-1:0]      r_col, n_col;
    logic [pcxrle_pkg::CUR_ROW_W-1:0]   r_row, n_row;

    // holding stage and output register
    logic                r_hold_valid, n_hold_valid;
    pcxrle_pkg::t_pixel  r_hold, n_hold;
    logic                r_out_valid, n_out_valid;
    pcxrle_pkg::t_pixel  r_out, n_out;
    logic                r_out_last, n_out_last;

    // derived geometry
    logic [pcxrle_pkg::WIDTH_W-1:0]  w_sat;
    logic [pcxrle_pkg::HEIGHT_W-1:0] h_sat;
    logic [pcxrle_pkg::BPL_W-1:0]    bpl_sat;
    logic [pcxrle_pkg::POS_W-1:0]    bpl_ext;
    logic [pcxrle_pkg::POS_W-1:0]    bpl2;
    logic [pcxrle_pkg::POS_W-1:0]    line_len;
    logic                            image_done;

    // stepper signals
    logic                            out_free;
    logic                            accept;
    logic                            step_en;
    logic                            flush_en;
    logic                            pos_end;
    logic                            emit;
    logic [pcxrle_pkg::POS_W-1:0]    pos_inc;
    logic                            plane_edge;
    logic                            line_done;
    logic                            step_last;
    logic                            is_marker;
    pcxrle_pkg::t_pixel              cur_pix;

    // geometry, saturated to the supported limits
    always_comb begin
        w_sat    = (r_width > pcxrle_pkg::MAX_DIM) ? pcxrle_pkg::MAX_DIM : r_width;
        h_sat    = (r_height > pcxrle_pkg::MAX_DIM) ? pcxrle_pkg::MAX_DIM : r_height;
        bpl_sat  = (r_bpl > pcxrle_pkg::MAX_LINE_BYTES) ? pcxrle_pkg::MAX_LINE_BYTES : r_bpl;
        bpl_ext  = {1'b0, bpl_sat};
        bpl2     = {bpl_sat, 1'b0};
        line_len = r_rgb ? (bpl_ext + bpl2) : bpl_ext;
        image_done = (bpl_sat == '0) || (r_row >= h_sat);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pcxrle_pkg::WIDTH_W'(1);
            r_height <= pcxrle_pkg::HEIGHT_W'(1);
            r_bpl    <= pcxrle_pkg::BPL_W'(1);
            r_rgb    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcxrle_pkg::CFG_IMAGE_WIDTH:
                    r_width  <= i_cfg_data[pcxrle_pkg::WIDTH_W-1:0];
                pcxrle_pkg::CFG_IMAGE_HEIGHT:
                    r_height <= i_cfg_data[pcxrle_pkg::HEIGHT_W-1:0];
                pcxrle_pkg::CFG_BYTES_PER_LINE:
                    r_bpl    <= i_cfg_data[pcxrle_pkg::BPL_W-1:0];
                pcxrle_pkg::CFG_RGB_MODE:
                    r_rgb    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // one line position step of the shared compare and increment unit
    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        pos_end    = (r_pos >= line_len);
        emit       = !pos_end && (r_col < {1'b0, w_sat});
        pos_inc    = r_pos + pcxrle_pkg::POS_W'(1);
        plane_edge = r_rgb && ((pos_inc == bpl_ext) || (pos_inc == bpl2));
        line_done  = pos_end || (pos_inc >= line_len);
        step_last  = line_done || (r_cnt == pcxrle_pkg::CNT_W'(1));
        is_marker  = ((i_in_byte & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK);
        cur_pix.col   = r_col[pcxrle_pkg::COL_W-1:0];
        cur_pix.row   = r_row[pcxrle_pkg::ROW_W-1:0];
        cur_pix.plane = r_plane;
        cur_pix.value = r_val;
    end

    // sequencer control outputs
    always_comb begin
        o_in_ready = 1'b0;
        step_en    = 1'b0;
        flush_en   = 1'b0;
        unique case (r_state)
            pcxrle_pkg::ST_IDLE:  o_in_ready = 1'b1;
            pcxrle_pkg::ST_RUN:   step_en    = !r_hold_valid || out_free;
            pcxrle_pkg::ST_FLUSH: flush_en   = out_free;
            default: ;
        endcase
        accept = i_in_valid && o_in_ready;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcxrle_pkg::ST_IDLE: begin
                if (accept && !image_done && !(!r_awaiting && is_marker)) begin
                    if (!r_awaiting || (r_pending != '0)) begin
                        n_state = pcxrle_pkg::ST_RUN;
                    end
                end
            end
            pcxrle_pkg::ST_RUN: begin
                if (step_en && step_last) begin
                    n_state = (r_hold_valid || emit) ? pcxrle_pkg::ST_FLUSH
                                                     : pcxrle_pkg::ST_IDLE;
                end
            end
            pcxrle_pkg::ST_FLUSH: begin
                if (flush_en) begin
                    n_state = pcxrle_pkg::ST_IDLE;
                end
            end
            default: n_state = pcxrle_pkg::ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_awaiting   = r_awaiting;
        n_pending    = r_pending;
        n_cnt        = r_cnt;
        n_val        = r_val;
        n_pos        = r_pos;
        n_plane      = r_plane;
        n_col        = r_col;
        n_row        = r_row;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        n_out_last   = r_out_last;

        // byte intake: marker, run value or literal
        if (accept && !image_done) begin
            n_val = i_in_byte;
            if (!r_awaiting && is_marker) begin
                n_awaiting = 1'b1;
                n_pending  = i_in_byte[pcxrle_pkg::CNT_W-1:0];
            end else if (r_awaiting) begin
                n_awaiting = 1'b0;
                n_pending  = '0;
                n_cnt      = r_pending;
            end else begin
                n_cnt      = pcxrle_pkg::CNT_W'(1);
            end
        end

        // position step with pixel write into the holding stage
        if (step_en) begin
            n_cnt = r_cnt - pcxrle_pkg::CNT_W'(1);
            if (emit) begin
                if (r_hold_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = r_hold;
                    n_out_last  = 1'b0;
                end
                n_hold_valid = 1'b1;
                n_hold       = cur_pix;
            end
            if (!pos_end) begin
                n_pos = pos_inc;
                if (plane_edge) begin
                    n_plane = (r_plane < pcxrle_pkg::PLANE_BLUE)
                            ? r_plane + pcxrle_pkg::PLANE_W'(1) : pcxrle_pkg::PLANE_BLUE;
                    n_col   = '0;
                end else begin
                    n_col   = r_col + pcxrle_pkg::PCOL_W'(1);
                end
            end
            if (line_done) begin
                n_pos   = '0;
                n_plane = pcxrle_pkg::PLANE_RED;
                n_col   = '0;
                n_row   = r_row + pcxrle_pkg::CUR_ROW_W'(1);
            end
        end

        // release the final write of the byte
        if (flush_en) begin
            n_hold_valid = 1'b0;
            n_out_valid  = 1'b1;
            n_out        = r_hold;
            n_out_last   = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pcxrle_pkg::ST_IDLE;
            r_awaiting   <= 1'b0;
            r_pending    <= '0;
            r_cnt        <= '0;
            r_pos        <= '0;
            r_plane      <= pcxrle_pkg::PLANE_RED;
            r_col        <= '0;
            r_row        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_awaiting   <= n_awaiting;
            r_pending    <= n_pending;
            r_cnt        <= n_cnt;
            r_pos        <= n_pos;
            r_plane      <= n_plane;
            r_col        <= n_col;
            r_row        <= n_row;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // output word
    assign o_out_valid    = r_out_valid;
    assign o_pixel_column = r_out.col;
    assign o_pixel_row    = r_out.row;
    assign o_plane_select = r_out.plane;
    assign o_pixel_value  = r_out.value;
    assign o_last_of_run  = r_out_last;

endmodule

/* tb/tb_pcx_rle_scanline_decoder.sv */
// ----------------------------------------------------------------------------
// tb_pcx_rle_scanline_decoder
// Self-checking bench for the run-length scanline decoder: a byte driver with
// bursty gaps and a stalling pixel sink, checked against an in-bench decoder
// that tracks line, plane and column position for every accepted byte.
// ----------------------------------------------------------------------------
module tb_pcx_rle_scanline_decoder;

    localparam int unsigned IDLE_CYCLES  = 100;
    localparam int unsigned LONG_HOLD    = 500;
    localparam int unsigned RAND_PHASES  = 8;
    localparam int unsigned PHASE_BYTES  = 56;
    localparam int unsigned PHASE_ROWS   = 64;

    // one expected or observed pixel write
    typedef struct packed {
        logic [pcxrle_pkg::COL_W-1:0]   col;
        logic [pcxrle_pkg::ROW_W-1:0]   row;
        logic [pcxrle_pkg::PLANE_W-1:0] plane;
        logic [pcxrle_pkg::IN_W-1:0]    value;
        logic                           last;
    } t_pixel_write;

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic                             i_cfg_we   = 1'b0;
    logic [pcxrle_pkg::CFG_IDX_W-1:0] i_cfg_idx  = pcxrle_pkg::CFG_IMAGE_WIDTH;
    logic [pcxrle_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic [pcxrle_pkg::IN_W-1:0]      i_in_byte  = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [pcxrle_pkg::COL_W-1:0]     o_pixel_column;
    logic [pcxrle_pkg::ROW_W-1:0]     o_pixel_row;
    logic [pcxrle_pkg::PLANE_W-1:0]   o_plane_select;
    logic [pcxrle_pkg::IN_W-1:0]      o_pixel_value;
    logic                             o_last_of_run;

    pcx_rle_scanline_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_plane_select (o_plane_select),
        .o_pixel_value  (o_pixel_value),
        .o_last_of_run  (o_last_of_run)
    );

    // clock: period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [pcxrle_pkg::IN_W-1:0] coded_bytes[$];
    t_pixel_write    expected_pixels[$];
    int unsigned     fail_count = 0;
    logic            byte_taken = 1'b0;
    int unsigned     hold_requests = 0;

    // shadow of the geometry registers
    logic [pcxrle_pkg::WIDTH_W-1:0]  geo_width  = 13'd1;
    logic [pcxrle_pkg::HEIGHT_W-1:0] geo_height = 13'd1;
    logic [pcxrle_pkg::BPL_W-1:0]    geo_bpl    = 14'd1;
    logic                            geo_rgb    = 1'b0;

    // decoder position state
    logic                             dec_awaiting = 1'b0;
    logic [pcxrle_pkg::CNT_W-1:0]     dec_pending  = '0;
    int unsigned                      dec_pos      = 0;
    logic [pcxrle_pkg::PLANE_W-1:0]   dec_plane    = pcxrle_pkg::PLANE_RED;
    logic [pcxrle_pkg::PCOL_W-1:0]    dec_pcol     = '0;
    logic [pcxrle_pkg::CUR_ROW_W-1:0] dec_row      = '0;

    task automatic start_next_line();
        dec_pos   = 0;
        dec_plane = pcxrle_pkg::PLANE_RED;
        dec_pcol  = '0;
        dec_row   = dec_row + pcxrle_pkg::CUR_ROW_W'(1);
    endtask

    // expand one coded byte into the pixel writes it should cause
    task automatic decode_byte(input logic [pcxrle_pkg::IN_W-1:0] b);
        int unsigned  w;
        int unsigned  h;
        int unsigned  bpl;
        int unsigned  len;
        int unsigned  count;
        int unsigned  n;
        t_pixel_write wr;
        logic         have_wr;
        w   = (geo_width > pcxrle_pkg::MAX_DIM) ? int'(pcxrle_pkg::MAX_DIM)
                                                 : int'(geo_width);
        h   = (geo_height > pcxrle_pkg::MAX_DIM) ? int'(pcxrle_pkg::MAX_DIM)
                                                  : int'(geo_height);
        bpl = (geo_bpl > pcxrle_pkg::MAX_LINE_BYTES) ? int'(pcxrle_pkg::MAX_LINE_BYTES)
                                                      : int'(geo_bpl);
        len = geo_rgb ? bpl * 3 : bpl;
        have_wr = 1'b0;
        wr = '0;
        // empty geometry or finished image: byte is dropped
        if (len == 0 || dec_row >= h) return;
        // run marker only records the count
        if (!dec_awaiting && (b & pcxrle_pkg::RUN_MARK) == pcxrle_pkg::RUN_MARK) begin
            dec_awaiting = 1'b1;
            dec_pending  = b[pcxrle_pkg::CNT_W-1:0];
            return;
        end
        count = dec_awaiting ? int'(dec_pending) : 1;
        dec_awaiting = 1'b0;
        dec_pending  = '0;
        for (n = 0; n < count; n++) begin
            if (dec_pos >= len) begin
                start_next_line();
                break;
            end
            if (dec_pcol < w) begin
                if (have_wr) expected_pixels.push_back(wr);
                wr.col   = dec_pcol[pcxrle_pkg::COL_W-1:0];
                wr.row   = dec_row[pcxrle_pkg::ROW_W-1:0];
                wr.plane = dec_plane;
                wr.value = b;
                wr.last  = 1'b0;
                have_wr  = 1'b1;
            end
            dec_pos++;
            if (geo_rgb && (dec_pos == bpl || dec_pos == bpl * 2)) begin
                dec_plane = (dec_plane < pcxrle_pkg::PLANE_BLUE)
                          ? dec_plane + pcxrle_pkg::PLANE_W'(1) : pcxrle_pkg::PLANE_BLUE;
                dec_pcol  = '0;
            end else begin
                dec_pcol = dec_pcol + pcxrle_pkg::PCOL_W'(1);
            end
            if (dec_pos >= len) begin
                start_next_line();
                break;
            end
        end
        if (have_wr) begin
            wr.last = 1'b1;
            expected_pixels.push_back(wr);
        end
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // predict accepted bytes, check accepted pixel writes
    always @(posedge i_clk) begin
        t_pixel_write want;
        byte_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) decode_byte(i_in_byte);
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected write, expected none, actual %0d %0d %0d %0h",
                             $time, o_pixel_column, o_pixel_row, o_plane_select,
                             o_pixel_value);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    report_field("pixel_column", 32'(want.col), 32'(o_pixel_column));
                    report_field("pixel_row", 32'(want.row), 32'(o_pixel_row));
                    report_field("plane_select", 32'(want.plane), 32'(o_plane_select));
                    report_field("pixel_value", 32'(want.value), 32'(o_pixel_value));
                    report_field("last_of_run", 32'(want.last), 32'(o_last_of_run));
                end
            end
        end
    end

    // byte driver: bursts of random length with random gaps
    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;
    always @(negedge i_clk) begin
        if (!i_in_valid || byte_taken) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (coded_bytes.size() > 0) begin
                i_in_byte  <= coded_bytes.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // pixel sink: stall pattern of its own, plus requested long hold-offs
    int unsigned hold_left  = 0;
    int unsigned holds_done = 0;
    int unsigned sink_mode  = 0;
    int unsigned sink_span  = 0;
    always @(negedge i_clk) begin
        if (holds_done != hold_requests) begin
            hold_left = LONG_HOLD;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (sink_span == 0) begin
                sink_mode = $urandom_range(0, 2);
                sink_span = $urandom_range(16, 96);
            end
            sink_span--;
            case (sink_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    task automatic write_cfg(input logic [pcxrle_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[pcxrle_pkg::CFG_DAT_W-1:0];
        case (idx)
            pcxrle_pkg::CFG_IMAGE_WIDTH:    geo_width  = data[pcxrle_pkg::WIDTH_W-1:0];
            pcxrle_pkg::CFG_IMAGE_HEIGHT:   geo_height = data[pcxrle_pkg::HEIGHT_W-1:0];
            pcxrle_pkg::CFG_BYTES_PER_LINE: geo_bpl    = data[pcxrle_pkg::BPL_W-1:0];
            default:                        geo_rgb    = data[0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned width, input int unsigned height,
                                input int unsigned bpl, input int unsigned rgb);
        write_cfg(pcxrle_pkg::CFG_IMAGE_WIDTH, width);
        write_cfg(pcxrle_pkg::CFG_IMAGE_HEIGHT, height);
        write_cfg(pcxrle_pkg::CFG_BYTES_PER_LINE, bpl);
        write_cfg(pcxrle_pkg::CFG_RGB_MODE, rgb);
        @(posedge i_clk);
    endtask

    // hold the driver until every write has come and the block has drained
    task automatic wait_idle();
        while (coded_bytes.size() != 0 || i_in_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_bytes(input logic [pcxrle_pkg::IN_W-1:0] seq[]);
        foreach (seq[i]) coded_bytes.push_back(seq[i]);
    endtask

    // mostly literals and run pairs, some raw noise
    task automatic queue_random_bytes(input int unsigned total);
        int unsigned                  left;
        int unsigned                  pick;
        logic [pcxrle_pkg::CNT_W-1:0] cnt;
        left = total;
        while (left > 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                coded_bytes.push_back(
                    pcxrle_pkg::IN_W'($urandom_range(0, pcxrle_pkg::RUN_MARK - 1)));
                left--;
            end else if (pick < 9 && left >= 2) begin
                cnt = ($urandom_range(0, 4) == 0) ? pcxrle_pkg::CNT_W'($urandom_range(0, 63))
                                                  : pcxrle_pkg::CNT_W'($urandom_range(0, 6));
                coded_bytes.push_back(pcxrle_pkg::RUN_MARK | {2'b00, cnt});
                coded_bytes.push_back(pcxrle_pkg::IN_W'($urandom_range(0, 255)));
                left -= 2;
            end else begin
                coded_bytes.push_back(pcxrle_pkg::IN_W'($urandom_range(0, 255)));
                left--;
            end
        end
    endtask

    // stimulus sequence
    initial begin
        int unsigned p;
        int unsigned bpl;
        int unsigned width;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: one literal fills the image, the rest is ignored
        push_bytes('{8'h00, 8'hBF, 8'hC5});
        wait_idle();

        // zero count, run of a marker value, exact line and overrun
        set_geometry(4096, dec_row + 4, 3, 0);
        push_bytes('{8'hC0, 8'h7F, 8'hC3, 8'hFF, 8'hC5, 8'hAA, 8'hBF, 8'hC2, 8'hC1});
        wait_idle();

        // oversized registers saturate, long run in rgb mode
        set_geometry(8191, 8191, 16383, 1);
        push_bytes('{8'hFF, 8'h11});
        wait_idle();

        // shrink line mid-image, then narrow and wide rows in rgb
        set_geometry(1, dec_row + 3, 2, 1);
        push_bytes('{8'h42, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20});
        wait_idle();
        write_cfg(pcxrle_pkg::CFG_IMAGE_WIDTH, 5);
        @(posedge i_clk);
        push_bytes('{8'hC7, 8'hE0});
        wait_idle();

        // empty line length and empty height ignore input
        write_cfg(pcxrle_pkg::CFG_BYTES_PER_LINE, 0);
        @(posedge i_clk);
        push_bytes('{8'hC4, 8'h33});
        wait_idle();
        write_cfg(pcxrle_pkg::CFG_BYTES_PER_LINE, 2);
        write_cfg(pcxrle_pkg::CFG_IMAGE_HEIGHT, 0);
        @(posedge i_clk);
        push_bytes('{8'h7E});
        wait_idle();

        // random phases with fresh geometry each
        for (p = 0; p < RAND_PHASES; p++) begin
            bpl = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0: width = $urandom_range(1, bpl);
                1: width = bpl;
                2: width = $urandom_range(bpl, bpl + 8);
                default: width = ($urandom_range(0, 1) == 0) ? 4096 : 8191;
            endcase
            set_geometry(width, dec_row + ((p == RAND_PHASES - 1) ? 3 : PHASE_ROWS),
                         bpl, $urandom_range(0, 1));
            queue_random_bytes(PHASE_BYTES);
            if (p == 1) hold_requests++;
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(4 * 2000000);
        $display("tb: failure");
        $finish;
    end

endmodule
